// ----- rtl/stl_pkg.sv -----
`default_nettype none
package stl_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int LENGTH_BITS = 16;
  localparam int KIND_BITS   = 6;
  localparam int MAX_RESULTS = 3;
  localparam int QUEUE_DEPTH = 4;

  typedef logic [KIND_BITS-1:0]   kind_t;
  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [LENGTH_BITS-1:0] length_t;

  typedef struct packed {
    kind_t   kind;
    offset_t start;
    length_t length;
    logic    last;
  } token_t;

  localparam length_t LENGTH_MAX = '1;

  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_DOLLAR     = 8'h24;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_SQUOTE     = 8'h27;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_COLON      = 8'h3A;

  localparam kind_t K_EOF        = 6'd0;
  localparam kind_t K_IDENT      = 6'd1;
  localparam kind_t K_LPAREN     = 6'd2;
  localparam kind_t K_RPAREN     = 6'd3;
  localparam kind_t K_LBRACKET   = 6'd4;
  localparam kind_t K_RBRACKET   = 6'd5;
  localparam kind_t K_LBRACE     = 6'd6;
  localparam kind_t K_RBRACE     = 6'd7;
  localparam kind_t K_SEMI       = 6'd8;
  localparam kind_t K_COLON      = 6'd9;
  localparam kind_t K_COMMA      = 6'd10;
  localparam kind_t K_DOT        = 6'd11;
  localparam kind_t K_RANGE      = 6'd12;
  localparam kind_t K_ELLIPSIS   = 6'd13;
  localparam kind_t K_AMP        = 6'd14;
  localparam kind_t K_PIPE       = 6'd15;
  localparam kind_t K_SHL        = 6'd16;
  localparam kind_t K_SHR        = 6'd17;
  localparam kind_t K_NOT        = 6'd18;
  localparam kind_t K_ANDAND     = 6'd19;
  localparam kind_t K_OROR       = 6'd20;
  localparam kind_t K_XOR        = 6'd21;
  localparam kind_t K_EQ         = 6'd22;
  localparam kind_t K_NE         = 6'd23;
  localparam kind_t K_LE         = 6'd24;
  localparam kind_t K_GE         = 6'd25;
  localparam kind_t K_LT         = 6'd26;
  localparam kind_t K_GT         = 6'd27;
  localparam kind_t K_ARROW      = 6'd28;
  localparam kind_t K_DARROW     = 6'd29;
  localparam kind_t K_QUESTION   = 6'd30;
  localparam kind_t K_ASSIGN     = 6'd31;
  localparam kind_t K_ADDA       = 6'd32;
  localparam kind_t K_SUBA       = 6'd33;
  localparam kind_t K_MULA       = 6'd34;
  localparam kind_t K_DIVA       = 6'd35;
  localparam kind_t K_MODA       = 6'd36;
  localparam kind_t K_SHLA       = 6'd37;
  localparam kind_t K_SHRA       = 6'd38;
  localparam kind_t K_ANDA       = 6'd39;
  localparam kind_t K_ORA        = 6'd40;
  localparam kind_t K_XORA       = 6'd41;
  localparam kind_t K_ORORA      = 6'd42;
  localparam kind_t K_ANDANDA    = 6'd43;
  localparam kind_t K_MOD        = 6'd44;
  localparam kind_t K_SLASH      = 6'd45;
  localparam kind_t K_STAR       = 6'd46;
  localparam kind_t K_PLUS       = 6'd47;
  localparam kind_t K_MINUS      = 6'd48;
  localparam kind_t K_SCOPE      = 6'd49;
  localparam kind_t K_INT        = 6'd50;
  localparam kind_t K_FLOAT      = 6'd51;
  localparam kind_t K_CHAR       = 6'd52;
  localparam kind_t K_STRING     = 6'd53;
  localparam kind_t K_UNT_CHAR   = 6'd54;
  localparam kind_t K_UNT_STRING = 6'd55;
  localparam kind_t K_INVALID    = 6'd56;
  // Marks "no token"; never leaves the block.
  localparam kind_t K_NONE       = 6'd63;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_UNDERSCORE);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  endfunction

  function automatic length_t sat_add(input length_t len, input logic [1:0] by);
    logic [LENGTH_BITS:0] sum;
    sum = {1'b0, len} + {{(LENGTH_BITS-1){1'b0}}, by};
    return sum[LENGTH_BITS] ? LENGTH_MAX : sum[LENGTH_BITS-1:0];
  endfunction

  // Kind of an operator after one more byte, or K_NONE when it cannot grow that way.
  function automatic kind_t extend(input kind_t k, input logic [7:0] c);
    kind_t r;
    r = K_NONE;
    unique case (k)
      K_COLON:  if (c == CH_COLON) r = K_SCOPE;
      K_DOT:    if (c == CH_DOT) r = K_RANGE;
      K_RANGE:  if (c == CH_DOT) r = K_ELLIPSIS;
      K_LT:     if (c == 8'h3C) r = K_SHL; else if (c == CH_EQUAL) r = K_LE;
      K_SHL:    if (c == CH_EQUAL) r = K_SHLA;
      K_GT:     if (c == 8'h3E) r = K_SHR; else if (c == CH_EQUAL) r = K_GE;
      K_SHR:    if (c == CH_EQUAL) r = K_SHRA;
      K_MOD:    if (c == CH_EQUAL) r = K_MODA;
      K_XOR:    if (c == CH_EQUAL) r = K_XORA;
      K_AMP:    if (c == 8'h26) r = K_ANDAND; else if (c == CH_EQUAL) r = K_ANDA;
      K_ANDAND: if (c == CH_EQUAL) r = K_ANDANDA;
      K_STAR:   if (c == CH_EQUAL) r = K_MULA;
      K_MINUS:  if (c == CH_EQUAL) r = K_SUBA; else if (c == 8'h3E) r = K_ARROW;
      K_ASSIGN: if (c == CH_EQUAL) r = K_EQ; else if (c == 8'h3E) r = K_DARROW;
      K_PIPE:   if (c == 8'h7C) r = K_OROR; else if (c == CH_EQUAL) r = K_ORA;
      K_OROR:   if (c == CH_EQUAL) r = K_ORORA;
      K_PLUS:   if (c == CH_EQUAL) r = K_ADDA;
      K_NOT:    if (c == CH_EQUAL) r = K_NE;
      K_SLASH:  if (c == CH_EQUAL) r = K_DIVA;
      default:  r = K_NONE;
    endcase
    return r;
  endfunction

  function automatic logic can_grow(input kind_t k);
    return (extend(k, CH_EQUAL) != K_NONE) || (extend(k, CH_DOT) != K_NONE) ||
           (extend(k, CH_COLON) != K_NONE);
  endfunction

  function automatic kind_t first_kind(input logic [7:0] c);
    kind_t r;
    unique case (c)
      8'h28:     r = K_LPAREN;
      8'h29:     r = K_RPAREN;
      8'h5B:     r = K_LBRACKET;
      8'h5D:     r = K_RBRACKET;
      8'h7B:     r = K_LBRACE;
      8'h7D:     r = K_RBRACE;
      8'h2C:     r = K_COMMA;
      8'h3B:     r = K_SEMI;
      CH_COLON:  r = K_COLON;
      CH_DOT:    r = K_DOT;
      8'h3C:     r = K_LT;
      8'h3E:     r = K_GT;
      CH_DOLLAR: r = K_MOD;
      8'h25:     r = K_MOD;
      8'h5E:     r = K_XOR;
      8'h26:     r = K_AMP;
      8'h2A:     r = K_STAR;
      8'h2D:     r = K_MINUS;
      CH_EQUAL:  r = K_ASSIGN;
      8'h7C:     r = K_PIPE;
      8'h2B:     r = K_PLUS;
      8'h3F:     r = K_QUESTION;
      8'h21:     r = K_NOT;
      8'h2F:     r = K_SLASH;
      default:   r = K_NONE;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/source_text_lexer_top.sv -----
`default_nettype none
// Byte-serial longest-match lexer. One source byte is taken per request on the
// in_ channel and the tokens it completes leave on the out_ channel, one per cycle
// while out_ready is high, in text order; last_of_run marks the final token caused
// by a byte. A zero byte ends the text: the pending token is flushed, an eof token
// follows, and offsets restart at zero. Each byte is lexed in the cycle it is
// accepted and its tokens (zero to three) are written into a four-entry result
// queue. The queue takes a new byte whenever it holds at most one token, so the
// block sustains one byte per cycle while bytes yield at most one token each and
// the output side keeps up; a byte that yields two or three tokens takes the count
// above one, and input stalls until it drains. There is no clearing pass after reset.
module source_text_lexer_top
  import stl_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic [7:0] in_text_byte,
  output logic    out_valid,
  input  logic    out_ready,
  output kind_t   out_token_kind,
  output offset_t out_token_start,
  output length_t out_token_length,
  output logic    out_last_of_run
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_NUMDOT,
    MODE_QUOTE,
    MODE_OP
  } mode_t;

  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_BITS = $clog2(QUEUE_DEPTH);
  localparam int RES_BITS = $clog2(MAX_RESULTS + 1);

  mode_t   mode_r, mode_nxt;
  kind_t   pend_kind_r, pend_kind_nxt;
  offset_t pend_start_r, pend_start_nxt;
  length_t pend_len_r, pend_len_nxt;
  logic    escape_r, escape_nxt;
  logic    fraction_r, fraction_nxt;
  logic    quote_dq_r, quote_dq_nxt;
  offset_t offset_r, offset_nxt;

  token_t  queue_r [QUEUE_DEPTH];
  token_t  queue_nxt [QUEUE_DEPTH];
  logic [CNT_BITS-1:0] count_r, count_nxt;

  token_t  res [MAX_RESULTS];
  logic [RES_BITS-1:0] res_n;

  logic    again;
  logic    emit_v;
  kind_t   emit_k;
  offset_t emit_s;
  length_t emit_l;
  kind_t   op_k;
  logic [7:0] c;

  logic push, pop;
  logic [CNT_BITS-1:0] base;
  logic [CNT_BITS-1:0] widx;

  assign c         = in_text_byte;
  assign out_valid = (count_r != '0);
  assign in_ready  = (count_r <= CNT_BITS'(1));
  assign pop       = out_valid && out_ready;
  assign push      = in_valid && in_ready;

  assign out_token_kind   = queue_r[0].kind;
  assign out_token_start  = queue_r[0].start;
  assign out_token_length = queue_r[0].length;
  assign out_last_of_run  = queue_r[0].last;

  // Lexer step: a byte may be looked at again after a token closes in front of it,
  // which happens at most twice per byte.
  always_comb begin
    mode_nxt       = mode_r;
    pend_kind_nxt  = pend_kind_r;
    pend_start_nxt = pend_start_r;
    pend_len_nxt   = pend_len_r;
    escape_nxt     = escape_r;
    fraction_nxt   = fraction_r;
    quote_dq_nxt   = quote_dq_r;
    res_n          = '0;
    again          = 1'b1;
    op_k           = K_NONE;
    for (int j = 0; j < MAX_RESULTS; j++) begin
      res[j] = '0;
    end
    for (int i = 0; i < MAX_RESULTS; i++) begin
      emit_v = 1'b0;
      emit_k = K_EOF;
      emit_s = pend_start_nxt;
      emit_l = pend_len_nxt;
      if (again && (res_n < RES_BITS'(MAX_RESULTS))) begin
        again = 1'b0;
        unique case (mode_nxt)
          MODE_IDENT: begin
            if (is_alpha(c) || is_digit(c)) begin
              pend_len_nxt = sat_add(pend_len_nxt, 2'd1);
            end else begin
              emit_v = 1'b1;
              emit_k = K_IDENT;
              again  = 1'b1;
            end
          end
          MODE_NUMBER: begin
            if (is_digit(c)) begin
              pend_len_nxt = sat_add(pend_len_nxt, 2'd1);
            end else if ((c == CH_DOT) && !fraction_nxt) begin
              mode_nxt = MODE_NUMDOT;
            end else begin
              emit_v = 1'b1;
              emit_k = fraction_nxt ? K_FLOAT : K_INT;
              again  = 1'b1;
            end
          end
          MODE_NUMDOT: begin
            if (is_digit(c)) begin
              pend_len_nxt  = sat_add(pend_len_nxt, 2'd2);
              fraction_nxt  = 1'b1;
              pend_kind_nxt = K_FLOAT;
              mode_nxt      = MODE_NUMBER;
            end else begin
              // The number ends before the dot; the dot becomes an operator.
              emit_v         = 1'b1;
              emit_k         = K_INT;
              mode_nxt       = MODE_OP;
              pend_kind_nxt  = K_DOT;
              pend_start_nxt = offset_r - OFFSET_BITS'(1);
              pend_len_nxt   = LENGTH_BITS'(1);
              escape_nxt     = 1'b0;
              fraction_nxt   = 1'b0;
              again          = 1'b1;
            end
          end
          MODE_QUOTE: begin
            if (c == CH_NUL) begin
              emit_v = 1'b1;
              emit_k = quote_dq_nxt ? K_UNT_STRING : K_UNT_CHAR;
              again  = 1'b1;
            end else if (escape_nxt) begin
              escape_nxt   = 1'b0;
              pend_len_nxt = sat_add(pend_len_nxt, 2'd1);
            end else if (c == (quote_dq_nxt ? CH_DQUOTE : CH_SQUOTE)) begin
              pend_len_nxt = sat_add(pend_len_nxt, 2'd1);
              emit_v       = 1'b1;
              emit_k       = quote_dq_nxt ? K_STRING : K_CHAR;
              emit_l       = pend_len_nxt;
            end else begin
              if (c == CH_BACKSLASH) begin
                escape_nxt = 1'b1;
              end
              pend_len_nxt = sat_add(pend_len_nxt, 2'd1);
            end
          end
          MODE_OP: begin
            op_k = extend(pend_kind_nxt, c);
            if ((pend_kind_nxt == K_DOT) && (pend_len_nxt == LENGTH_BITS'(1)) &&
                is_digit(c)) begin
              pend_len_nxt  = LENGTH_BITS'(2);
              fraction_nxt  = 1'b1;
              pend_kind_nxt = K_FLOAT;
              mode_nxt      = MODE_NUMBER;
            end else if (op_k != K_NONE) begin
              pend_kind_nxt = op_k;
              pend_len_nxt  = sat_add(pend_len_nxt, 2'd1);
              if (!can_grow(op_k)) begin
                emit_v = 1'b1;
                emit_k = op_k;
                emit_l = pend_len_nxt;
              end
            end else begin
              emit_v = 1'b1;
              emit_k = pend_kind_nxt;
              again  = 1'b1;
            end
          end
          default: begin
            mode_nxt = MODE_IDLE;
            op_k     = first_kind(c);
            if (c == CH_NUL) begin
              emit_v = 1'b1;
              emit_k = K_EOF;
              emit_s = offset_r;
              emit_l = '0;
            end else if (is_space(c)) begin
              mode_nxt = MODE_IDLE;
            end else if (is_alpha(c) || is_digit(c) || (c == CH_DQUOTE) ||
                         (c == CH_SQUOTE) || ((op_k != K_NONE) && can_grow(op_k))) begin
              pend_start_nxt = offset_r;
              pend_len_nxt   = LENGTH_BITS'(1);
              escape_nxt     = 1'b0;
              fraction_nxt   = 1'b0;
              if (is_alpha(c)) begin
                mode_nxt      = MODE_IDENT;
                pend_kind_nxt = K_IDENT;
              end else if (is_digit(c)) begin
                mode_nxt      = MODE_NUMBER;
                pend_kind_nxt = K_INT;
              end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
                mode_nxt      = MODE_QUOTE;
                pend_kind_nxt = (c == CH_DQUOTE) ? K_STRING : K_CHAR;
                quote_dq_nxt  = (c == CH_DQUOTE);
              end else begin
                mode_nxt      = MODE_OP;
                pend_kind_nxt = op_k;
              end
            end else begin
              emit_v = 1'b1;
              emit_k = (op_k == K_NONE) ? K_INVALID : op_k;
              emit_s = offset_r;
              emit_l = LENGTH_BITS'(1);
            end
          end
        endcase
      end
      if (emit_v) begin
        res[res_n[IDX_BITS-1:0]] = '{kind: emit_k, start: emit_s, length: emit_l,
                                     last: 1'b0};
        res_n = res_n + RES_BITS'(1);
        // A token handed out from the pending slot leaves the lexer between tokens.
        if (mode_nxt != MODE_OP || emit_k != K_INT) begin
          if (emit_k != K_EOF && emit_k != K_INVALID &&
              !(emit_l == LENGTH_BITS'(1) && emit_s == offset_r &&
                mode_nxt == MODE_IDLE)) begin
            mode_nxt     = MODE_IDLE;
            escape_nxt   = 1'b0;
            fraction_nxt = 1'b0;
          end
        end
      end
    end
    for (int j = 0; j < MAX_RESULTS; j++) begin
      res[j].last = (res_n != '0) && (RES_BITS'(j) == (res_n - RES_BITS'(1)));
    end
    if (c == CH_NUL) begin
      mode_nxt       = MODE_IDLE;
      pend_kind_nxt  = K_EOF;
      pend_start_nxt = '0;
      pend_len_nxt   = '0;
      escape_nxt     = 1'b0;
      fraction_nxt   = 1'b0;
      quote_dq_nxt   = 1'b0;
      offset_nxt     = '0;
    end else begin
      offset_nxt = offset_r + OFFSET_BITS'(1);
    end
  end

  // Result queue: head at entry 0, shifted whenever a token is taken at the output.
  always_comb begin
    base  = count_r - CNT_BITS'(pop);
    widx  = base;
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      queue_nxt[j] = queue_r[j];
    end
    if (pop) begin
      for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
        queue_nxt[j] = queue_r[j+1];
      end
    end
    if (push) begin
      for (int j = 0; j < MAX_RESULTS; j++) begin
        widx = base + CNT_BITS'(j);
        if (RES_BITS'(j) < res_n) begin
          queue_nxt[widx[IDX_BITS-1:0]] = res[j];
        end
      end
    end
    count_nxt = base + (push ? CNT_BITS'(res_n) : CNT_BITS'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      pend_kind_r  <= K_EOF;
      pend_start_r <= '0;
      pend_len_r   <= '0;
      escape_r     <= 1'b0;
      fraction_r   <= 1'b0;
      quote_dq_r   <= 1'b0;
      offset_r     <= '0;
      count_r      <= '0;
    end else begin
      if (push) begin
        mode_r       <= mode_nxt;
        pend_kind_r  <= pend_kind_nxt;
        pend_start_r <= pend_start_nxt;
        pend_len_r   <= pend_len_nxt;
        escape_r     <= escape_nxt;
        fraction_r   <= fraction_nxt;
        quote_dq_r   <= quote_dq_nxt;
        offset_r     <= offset_nxt;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      queue_r[j] <= queue_nxt[j];
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind == K_EOF) |-> out_last_of_run)
    else $error("eof token is not the last of its run");

  a_offset_restart: assert property (@(posedge clk) disable iff (!rst_n)
    push && (in_text_byte == CH_NUL) |=> (offset_r == '0))
    else $error("offset did not restart after end of text");

  a_result_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push && (res_n != '0) |=> out_valid)
    else $error("token of an accepted byte is missing at the output");
`endif

endmodule
`default_nettype wire

// ----- verif/source_text_lexer_top_tb.sv -----
module source_text_lexer_top_tb;
  import stl_pkg::*;

  localparam int RANDOM_BYTES   = 300;
  localparam int QUIET_TAIL     = 40;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef enum logic [2:0] {
    LX_IDLE, LX_IDENT, LX_NUMBER, LX_NUMDOT, LX_QUOTE, LX_OP
  } lex_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_text_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  kind_t out_token_kind;
  offset_t out_token_start;
  length_t out_token_length;
  logic out_last_of_run;

  source_text_lexer_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_text_byte(in_text_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_token_kind(out_token_kind),
    .out_token_start(out_token_start),
    .out_token_length(out_token_length),
    .out_last_of_run(out_last_of_run)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [7:0] text_q[$];
  token_t token_q[$];
  token_t run_tokens[$];
  string op_words[0:49];
  int produced = 0;
  int accepted_bytes = 0;
  int noisy_count = 32'h7fffffff;
  int errors = 0;
  int idle_cycles = 0;
  int send_burst = 0, send_stretch = 0, recv_burst = 0, recv_stretch = 0;
  bit send_calm = 1'b0, recv_calm = 1'b0;

  // Lexer state as the testbench sees it.
  lex_mode_t lex_mode = LX_IDLE;
  kind_t pend_kind = K_EOF;
  offset_t pend_start = '0;
  length_t pend_len = '0;
  logic in_escape = 1'b0;
  logic in_fraction = 1'b0;
  logic dquote = 1'b0;
  offset_t text_offset = '0;

  function automatic logic digit_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic word_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDERSCORE;
  endfunction

  function automatic logic blank_char(input logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  function automatic length_t grow_len(input length_t len, input int unsigned by);
    longint s;
    s = longint'(len) + by;
    return (s > longint'(LENGTH_MAX)) ? LENGTH_MAX : length_t'(s);
  endfunction

  // Operator reached by appending c to an operator of kind k, or K_NONE.
  function automatic kind_t op_grow(input kind_t k, input logic [7:0] c);
    kind_t r;
    r = K_NONE;
    case (k)
      K_COLON:  if (c == ":") r = K_SCOPE;
      K_DOT:    if (c == ".") r = K_RANGE;
      K_RANGE:  if (c == ".") r = K_ELLIPSIS;
      K_LT:     if (c == "<") r = K_SHL; else if (c == "=") r = K_LE;
      K_SHL:    if (c == "=") r = K_SHLA;
      K_GT:     if (c == ">") r = K_SHR; else if (c == "=") r = K_GE;
      K_SHR:    if (c == "=") r = K_SHRA;
      K_MOD:    if (c == "=") r = K_MODA;
      K_XOR:    if (c == "=") r = K_XORA;
      K_AMP:    if (c == "&") r = K_ANDAND; else if (c == "=") r = K_ANDA;
      K_ANDAND: if (c == "=") r = K_ANDANDA;
      K_STAR:   if (c == "=") r = K_MULA;
      K_MINUS:  if (c == "=") r = K_SUBA; else if (c == ">") r = K_ARROW;
      K_ASSIGN: if (c == "=") r = K_EQ; else if (c == ">") r = K_DARROW;
      K_PIPE:   if (c == "|") r = K_OROR; else if (c == "=") r = K_ORA;
      K_OROR:   if (c == "=") r = K_ORORA;
      K_PLUS:   if (c == "=") r = K_ADDA;
      K_NOT:    if (c == "=") r = K_NE;
      K_SLASH:  if (c == "=") r = K_DIVA;
      default:  r = K_NONE;
    endcase
    return r;
  endfunction

  function automatic logic op_growable(input kind_t k);
    case (k)
      K_COLON, K_DOT, K_RANGE, K_LT, K_SHL, K_GT, K_SHR, K_MOD, K_XOR, K_AMP,
      K_ANDAND, K_STAR, K_MINUS, K_ASSIGN, K_PIPE, K_OROR, K_PLUS, K_NOT,
      K_SLASH: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic kind_t starter_kind(input logic [7:0] c);
    case (c)
      "(": return K_LPAREN;
      ")": return K_RPAREN;
      "[": return K_LBRACKET;
      "]": return K_RBRACKET;
      "{": return K_LBRACE;
      "}": return K_RBRACE;
      ",": return K_COMMA;
      ";": return K_SEMI;
      ":": return K_COLON;
      ".": return K_DOT;
      "<": return K_LT;
      ">": return K_GT;
      "$", "%": return K_MOD;
      "^": return K_XOR;
      "&": return K_AMP;
      "*": return K_STAR;
      "-": return K_MINUS;
      "=": return K_ASSIGN;
      "|": return K_PIPE;
      "+": return K_PLUS;
      "?": return K_QUESTION;
      "!": return K_NOT;
      "/": return K_SLASH;
      default: return K_NONE;
    endcase
  endfunction

  task automatic emit_token(input kind_t k, input offset_t start, input length_t len);
    token_t t;
    if (run_tokens.size() < MAX_RESULTS) begin
      t.kind = k;
      t.start = start;
      t.length = len;
      t.last = 1'b0;
      run_tokens.push_back(t);
    end
  endtask

  task automatic close_token(input kind_t k);
    emit_token(k, pend_start, pend_len);
    lex_mode = LX_IDLE;
    in_escape = 1'b0;
    in_fraction = 1'b0;
  endtask

  task automatic open_token(input lex_mode_t m, input kind_t k, input offset_t start);
    lex_mode = m;
    pend_kind = k;
    pend_start = start;
    pend_len = length_t'(1);
    in_escape = 1'b0;
    in_fraction = 1'b0;
  endtask

  // Advances the lexer by one byte and queues the tokens that byte completes.
  task automatic lex_byte(input logic [7:0] c);
    offset_t here;
    logic again;
    kind_t k;
    here = text_offset;
    again = 1'b1;
    run_tokens.delete();
    while (again && run_tokens.size() < MAX_RESULTS) begin
      again = 1'b0;
      case (lex_mode)
        LX_IDENT: begin
          if (word_char(c) || digit_char(c)) pend_len = grow_len(pend_len, 1);
          else begin
            close_token(K_IDENT);
            again = 1'b1;
          end
        end
        LX_NUMBER: begin
          if (digit_char(c)) pend_len = grow_len(pend_len, 1);
          else if (c == CH_DOT && !in_fraction) lex_mode = LX_NUMDOT;
          else begin
            close_token(in_fraction ? K_FLOAT : K_INT);
            again = 1'b1;
          end
        end
        LX_NUMDOT: begin
          if (digit_char(c)) begin
            pend_len = grow_len(pend_len, 2);
            in_fraction = 1'b1;
            pend_kind = K_FLOAT;
            lex_mode = LX_NUMBER;
          end else begin
            // The dot did not start a fraction, so it becomes an operator of its own.
            close_token(K_INT);
            open_token(LX_OP, K_DOT, here - offset_t'(1));
            again = 1'b1;
          end
        end
        LX_QUOTE: begin
          if (c == CH_NUL) begin
            close_token(dquote ? K_UNT_STRING : K_UNT_CHAR);
            again = 1'b1;
          end else if (in_escape) begin
            in_escape = 1'b0;
            pend_len = grow_len(pend_len, 1);
          end else if (c == (dquote ? CH_DQUOTE : CH_SQUOTE)) begin
            pend_len = grow_len(pend_len, 1);
            close_token(dquote ? K_STRING : K_CHAR);
          end else begin
            if (c == CH_BACKSLASH) in_escape = 1'b1;
            pend_len = grow_len(pend_len, 1);
          end
        end
        LX_OP: begin
          if (pend_kind == K_DOT && pend_len == length_t'(1) && digit_char(c)) begin
            pend_len = length_t'(2);
            in_fraction = 1'b1;
            pend_kind = K_FLOAT;
            lex_mode = LX_NUMBER;
          end else begin
            k = op_grow(pend_kind, c);
            if (k != K_NONE) begin
              pend_kind = k;
              pend_len = grow_len(pend_len, 1);
              if (!op_growable(k)) close_token(k);
            end else begin
              close_token(pend_kind);
              again = 1'b1;
            end
          end
        end
        default: begin
          lex_mode = LX_IDLE;
          if (c == CH_NUL) emit_token(K_EOF, here, length_t'(0));
          else if (blank_char(c)) begin
          end else if (word_char(c)) open_token(LX_IDENT, K_IDENT, here);
          else if (digit_char(c)) open_token(LX_NUMBER, K_INT, here);
          else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            open_token(LX_QUOTE, (c == CH_DQUOTE) ? K_STRING : K_CHAR, here);
            dquote = (c == CH_DQUOTE);
          end else begin
            k = starter_kind(c);
            if (k == K_NONE) emit_token(K_INVALID, here, length_t'(1));
            else if (op_growable(k)) open_token(LX_OP, k, here);
            else emit_token(k, here, length_t'(1));
          end
        end
      endcase
    end
    if (c == CH_NUL) begin
      lex_mode = LX_IDLE;
      pend_kind = K_EOF;
      pend_start = '0;
      pend_len = '0;
      in_escape = 1'b0;
      in_fraction = 1'b0;
      dquote = 1'b0;
      text_offset = '0;
    end else begin
      text_offset = here + offset_t'(1);
    end
    if (run_tokens.size() > 0) run_tokens[run_tokens.size() - 1].last = 1'b1;
    foreach (run_tokens[i]) token_q.push_back(run_tokens[i]);
  endtask

  task automatic put(input logic [7:0] c);
    text_q.push_back(c);
    if (!blank_char(c)) produced++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  function automatic logic [7:0] rand_word_char(input bit with_digits);
    int r;
    r = $urandom_range(0, with_digits ? 62 : 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + (r - 26));
    if (r == 52) return CH_UNDERSCORE;
    return 8'("0" + (r - 53));
  endfunction

  task automatic put_digits(input int lo, input int hi);
    int n;
    n = $urandom_range(lo, hi);
    for (int i = 0; i < n; i++) put(8'("0" + $urandom_range(0, 9)));
  endtask

  // One random well-formed token, now and then noise, a zero byte or a broken quote.
  task automatic add_random_token();
    int n;
    logic [7:0] q;
    logic [7:0] b;
    case ($urandom_range(0, 11))
      0, 1: begin
        put(rand_word_char(1'b0));
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) put(rand_word_char(1'b1));
      end
      2: put_digits(1, 4);
      3: begin
        put_digits(1, 3);
        put(CH_DOT);
        put_digits(1, 3);
        if ($urandom_range(0, 2) == 0) begin
          put(CH_DOT);
          put_digits(0, 2);
        end
      end
      4: begin
        put_digits(1, 3);
        put(CH_DOT);
        put(op_words[$urandom_range(0, 49)][0]);
      end
      5, 6, 7: put_text(op_words[$urandom_range(0, 49)]);
      8: begin
        q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        put(q);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          b = 8'($urandom_range(1, 255));
          if (b == q) put(CH_BACKSLASH);
          put(b);
          if (b == CH_BACKSLASH) put(8'($urandom_range(1, 255)));
        end
        if ($urandom_range(0, 7) != 0) put(q);
      end
      9: put(8'($urandom_range(1, 255)));
      10: put(CH_NUL);
      default: begin
        put(CH_DOT);
        put_digits(1, 3);
      end
    endcase
    case ($urandom_range(0, 5))
      2: put(" ");
      3: put(8'h09);
      4: put(8'h0D);
      5: put(8'h0A);
      default: ;
    endcase
  endtask

  // Random idle bursts, switched off in calm stretches and in the tail.
  task automatic pace(inout int burst, inout int stretch, inout bit calm, output bit hold);
    if (stretch == 0) begin
      stretch = $urandom_range(16, 96);
      calm = ($urandom_range(0, 2) == 0);
    end
    stretch--;
    if (burst > 0) begin
      burst--;
      hold = 1'b1;
    end else if (accepted_bytes < noisy_count && !calm && $urandom_range(0, 4) == 0) begin
      burst = $urandom_range(0, 3);
      hold = 1'b1;
    end else begin
      hold = 1'b0;
    end
  endtask

  always @(posedge clk) begin : drive_requests
    bit hold;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      pace(send_burst, send_stretch, send_calm, hold);
      if (hold || text_q.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_text_byte <= text_q.pop_front();
      end
    end
  end

  always @(posedge clk) begin : pace_results
    bit hold;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      pace(recv_burst, recv_stretch, recv_calm, hold);
      out_ready <= !hold;
    end
  end

  // Prediction runs before the check so a token from the same edge would still match.
  always @(posedge clk) begin : check_tokens
    token_t want;
    token_t got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        lex_byte(in_text_byte);
        accepted_bytes++;
      end
      if (out_valid && out_ready) begin
        got.kind = out_token_kind;
        got.start = out_token_start;
        got.length = out_token_length;
        got.last = out_last_of_run;
        if (token_q.size() == 0) begin
          $display("%0t: unexpected token: kind %0d start %0d length %0d last %0b",
                   $time, got.kind, got.start, got.length, got.last);
          errors++;
        end else begin
          want = token_q.pop_front();
          if (got !== want) begin
            $display("%0t: token mismatch: expected kind %0d start %0d length %0d last %0b",
                     $time, want.kind, want.start, want.length, want.last);
            $display("%0t:                 actual   kind %0d start %0d length %0d last %0b",
                     $time, got.kind, got.start, got.length, got.last);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    op_words = '{"(", ")", "[", "]", "{", "}", ";", ":", ",", ".",
                 "..", "...", "&", "|", "<<", ">>", "!", "&&", "||", "^",
                 "==", "!=", "<=", ">=", "<", ">", "->", "=>", "?", "=",
                 "+=", "-=", "*=", "/=", "%=", "$=", "<<=", ">>=", "&=", "|=",
                 "^=", "||=", "&&=", "%", "$", "/", "*", "+", "-", "::"};

    // Directed text: number/dot splits, a second dot in a float, dollar and percent,
    // an escaped closing quote, an unterminated string ending on a backslash,
    // the top byte value, an unterminated character and a flush of three tokens.
    put_text("x9_ 3.e 1.5.5 $= ...<<= %");
    put(8'h01);
    put_text(" '\\'' \"a\\");
    put(CH_NUL);
    put(8'hFF);
    put_text(" '");
    put(CH_NUL);
    put_text("7.");
    put(CH_NUL);

    produced = 0;
    while (produced < RANDOM_BYTES) add_random_token();
    put(CH_NUL);
    noisy_count = text_q.size() - QUIET_TAIL;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (text_q.size() != 0 || in_valid || token_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && token_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/stl_pkg.sv
rtl/source_text_lexer_top.sv
verif/source_text_lexer_top_tb.sv
